// ----- rtl/core/mfc_pkg.sv -----
// ----------------------------------------------------------------------------
// mfc_pkg
// Shared types and constants of the magnetometer frame compensation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mfc_pkg;

    localparam int OUT_FRAC_BITS_DEF = 4;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;

    // raw field widths
    localparam int RAW_XY_W = 13;
    localparam int RAW_Z_W  = 15;
    localparam int RAW_H_W  = 14;
    localparam int COMP_W   = 20;

    // overflow markers of the sensor
    localparam logic [RAW_XY_W-1:0] XY_OVF = 13'h1000;
    localparam logic [RAW_Z_W-1:0]  Z_OVF  = 15'h4000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_XY_OFFSETS   = 3'd0,
        CFG_XY_GAINS     = 3'd1,
        CFG_XY_CURVE     = 3'd2,
        CFG_Z_SENS       = 3'd3,
        CFG_Z_BASE       = 3'd4,
        CFG_Z_RES_SLOPE  = 3'd5,
        CFG_Z_OFFSET     = 3'd6,
        CFG_REF_RES      = 3'd7
    } cfg_index_t;

    // raw fields plus the x/y zero flags, carried along the pipeline
    typedef struct packed {
        logic [RAW_XY_W-1:0] rx;
        logic [RAW_XY_W-1:0] ry;
        logic [RAW_Z_W-1:0]  rz;
        logic [RAW_H_W-1:0]  rh;
        logic                x_zero;
        logic                y_zero;
    } raw_t;

    // sideband of the z divider
    typedef struct packed {
        logic neg;
        logic zero;
    } zside_t;

endpackage

`default_nettype wire

// ----- rtl/core/magnetometer_frame_compensation_unit.sv -----
// ----------------------------------------------------------------------------
// magnetometer_frame_compensation_unit
// Unpacks one 8-byte magnetometer frame and applies trim compensation to X,
// Y and Z, giving raw fields and saturated 20-bit compensated values.
// ----------------------------------------------------------------------------
//  channel | ports                     | direction | word
//  --------+---------------------------+-----------+---------------------------
//  input   | s_valid s_ready s_data_*  | in        | 64-bit data frame
//  result  | m_valid m_ready m_raw_*/  | out       | raw fields, comp x/y/z
//          | m_comp_*                  |           |
//  config  | cfg_wr_en cfg_index       | in        | 16-bit trim register
//          | cfg_wdata                 |           |
//
//  one word accepted per cycle while the result word is not held; the two
//  bit-per-stage dividers have 35 + OUT_FRAC_BITS stages each
//  reset is synchronous: clears all valid bits and the trim registers
//  a held result word freezes the whole pipeline; s_ready = !m_valid | m_ready
//  trim registers: user keeps them static (not enforced) while words are in flight
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_frame_compensation_unit
    import mfc_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // config write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input frame
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [63:0]           s_data_frame,
    // result
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [12:0]         m_raw_x,
    output logic signed [12:0]         m_raw_y,
    output logic signed [14:0]         m_raw_z,
    output logic [13:0]                m_raw_hall,
    output logic signed [19:0]         m_comp_x,
    output logic signed [19:0]         m_comp_y,
    output logic signed [19:0]         m_comp_z
);

    // divider sizes: |N| fits 35 bits, shifted by the output fraction
    localparam int ZNW  = 35 + OUT_FRAC_BITS;
    localparam int ZDW  = 23;
    localparam int NUMW = 58 + OUT_FRAC_BITS;
    localparam int SW   = NUMW - 17;
    localparam int RPW  = $bits(raw_t);
    localparam int ZPW  = $bits(zside_t);

    localparam logic signed [SW-1:0] SAT_HI = SW'(524287);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(524288);
    localparam logic signed [43:0]   P2_LIM = 44'sd4294967296;

    function automatic logic [19:0] sat_out(input logic signed [SW-1:0] v);
        logic [19:0] res;
        if (v > SAT_HI) begin
            res = 20'h7ffff;
        end else if (v < SAT_LO) begin
            res = 20'h80000;
        end else begin
            res = v[19:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // trim registers
    // ------------------------------------------------------------------
    logic [15:0] xy_offsets_reg, xy_gains_reg, xy_curve_reg, z_sens_reg;
    logic [15:0] z_base_reg, z_slope_reg, z_offset_reg, ref_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xy_offsets_reg <= '0;
            xy_gains_reg   <= '0;
            xy_curve_reg   <= '0;
            z_sens_reg     <= '0;
            z_base_reg     <= '0;
            z_slope_reg    <= '0;
            z_offset_reg   <= '0;
            ref_res_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_XY_OFFSETS:  xy_offsets_reg <= cfg_wdata;
                CFG_XY_GAINS:    xy_gains_reg   <= cfg_wdata;
                CFG_XY_CURVE:    xy_curve_reg   <= cfg_wdata;
                CFG_Z_SENS:      z_sens_reg     <= cfg_wdata;
                CFG_Z_BASE:      z_base_reg     <= cfg_wdata;
                CFG_Z_RES_SLOPE: z_slope_reg    <= cfg_wdata;
                CFG_Z_OFFSET:    z_offset_reg   <= cfg_wdata;
                CFG_REF_RES:     ref_res_reg    <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // whole pipeline advances together unless the result word is held
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ------------------------------------------------------------------
    // stage 1: unpack the frame
    // ------------------------------------------------------------------
    logic                v1_reg;
    logic [RAW_XY_W-1:0] rx1_reg, ry1_reg;
    logic [RAW_Z_W-1:0]  rz1_reg;
    logic [RAW_H_W-1:0]  rh1_reg;

    // ------------------------------------------------------------------
    // stage 2: z products and differences, zero flags
    // ------------------------------------------------------------------
    logic               v2_reg;
    raw_t               raw2_reg;
    logic               zz2_reg;
    logic [29:0]        zp1_2_reg;
    logic signed [32:0] zp3_2_reg;
    logic signed [16:0] zdiff2_reg;

    logic [29:0]        zp1_next;
    logic signed [16:0] rdiff;
    logic signed [32:0] zp3_next;
    logic signed [16:0] zdiff_next;
    logic               hz;
    raw_t               raw2_next;

    always_comb begin
        zp1_next   = z_sens_reg * rh1_reg;
        rdiff      = $signed({3'b000, rh1_reg}) - $signed({1'b0, ref_res_reg});
        zp3_next   = $signed(z_slope_reg) * rdiff;
        zdiff_next = $signed({{2{rz1_reg[RAW_Z_W-1]}}, rz1_reg})
                   - $signed({z_offset_reg[15], z_offset_reg});
        // no hall resistance or no reference resistance kills all axes
        hz         = (rh1_reg == '0) || (ref_res_reg == '0);
        raw2_next.rx     = rx1_reg;
        raw2_next.ry     = ry1_reg;
        raw2_next.rz     = rz1_reg;
        raw2_next.rh     = rh1_reg;
        raw2_next.x_zero = hz || (rx1_reg == XY_OVF);
        raw2_next.y_zero = hz || (ry1_reg == XY_OVF);
    end

    // ------------------------------------------------------------------
    // stage 3: z numerator and divisor sum
    // ------------------------------------------------------------------
    logic               v3_reg;
    raw_t               raw3_reg;
    logic               zz3_reg;
    logic signed [34:0] n3_reg;
    logic signed [17:0] sum3_reg;

    logic signed [34:0] n_next;
    logic signed [17:0] sum_next;

    always_comb begin
        n_next   = $signed({zdiff2_reg[16], zdiff2_reg, 17'b0})
                 - $signed({{2{zp3_2_reg[32]}}, zp3_2_reg});
        sum_next = $signed({{2{z_base_reg[15]}}, z_base_reg})
                 + $signed({3'b000, zp1_2_reg[29:15]});
    end

    // divider operands: magnitudes, sign handled after the quotient
    logic [34:0]    n_mag;
    logic [17:0]    s_mag;
    logic [ZNW-1:0] zdiv_num;
    logic [ZDW-1:0] zdiv_den;
    logic [ZNW-1:0] xdiv_num;
    zside_t         zside_in;

    always_comb begin
        n_mag         = n3_reg[34] ? 35'(-n3_reg) : 35'(n3_reg);
        s_mag         = sum3_reg[17] ? 18'(-sum3_reg) : 18'(sum3_reg);
        zdiv_num      = ZNW'(n_mag) << OUT_FRAC_BITS;
        zdiv_den      = {s_mag[16:0], 6'b0};
        xdiv_num      = ZNW'({ref_res_reg, 14'b0});
        zside_in.neg  = n3_reg[34] ^ sum3_reg[17];
        zside_in.zero = zz3_reg || (sum3_reg == '0);
    end

    // ------------------------------------------------------------------
    // dividers: xyz1*16384 / rhall and the z quotient, run side by side
    // ------------------------------------------------------------------
    logic           xdiv_valid, zdiv_valid;
    logic [ZNW-1:0] xdiv_quo, zdiv_quo;
    logic [RPW-1:0] xdiv_pay;
    logic [ZPW-1:0] zdiv_pay;
    raw_t           raw_d;
    zside_t         zside_d;

    mfc_div #(
        .NW (ZNW),
        .DW (RAW_H_W),
        .PW (RPW)
    ) u_xdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_num    (xdiv_num),
        .in_den    (raw3_reg.rh),
        .in_pay    (raw3_reg),
        .out_valid (xdiv_valid),
        .out_quo   (xdiv_quo),
        .out_pay   (xdiv_pay)
    );

    mfc_div #(
        .NW (ZNW),
        .DW (ZDW),
        .PW (ZPW)
    ) u_zdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_num    (zdiv_num),
        .in_den    (zdiv_den),
        .in_pay    (zside_in),
        .out_valid (zdiv_valid),
        .out_quo   (zdiv_quo),
        .out_pay   (zdiv_pay)
    );

    assign raw_d   = raw_t'(xdiv_pay);
    assign zside_d = zside_t'(zdiv_pay);

    // ------------------------------------------------------------------
    // stage a: resistance term r, signed and saturated z
    // ------------------------------------------------------------------
    logic               va_reg;
    raw_t               rawa_reg;
    logic signed [31:0] ra_reg;
    logic [19:0]        zca_reg;

    logic signed [31:0] r_next;
    logic [19:0]        zc_next;

    always_comb begin
        r_next = $signed({2'b00, xdiv_quo[29:0]}) - 32'sd16384;
        if (zside_d.zero) begin
            zc_next = '0;
        end else if (zside_d.neg) begin
            zc_next = (zdiv_quo > ZNW'(524288)) ? 20'h80000
                    : (~zdiv_quo[19:0]) + 20'd1;
        end else begin
            zc_next = (zdiv_quo > ZNW'(524287)) ? 20'h7ffff : zdiv_quo[19:0];
        end
    end

    // ------------------------------------------------------------------
    // stage b: r squared and r*xy1
    // ------------------------------------------------------------------
    logic               vb_reg;
    raw_t               rawb_reg;
    logic [19:0]        zcb_reg;
    logic [60:0]        sqb_reg;
    logic signed [40:0] rxyb_reg;

    logic signed [63:0] sq_full;
    logic signed [40:0] rxy_next;

    always_comb begin
        sq_full  = ra_reg * ra_reg;
        rxy_next = ra_reg * $signed({1'b0, xy_curve_reg[7:0]});
    end

    // ------------------------------------------------------------------
    // stage c: p2 = xy2*(r*r >> 28) + floor(r*xy1 / 2^14)
    // ------------------------------------------------------------------
    logic               vc_reg;
    raw_t               rawc_reg;
    logic [19:0]        zcc_reg;
    logic signed [42:0] p2c_reg;

    logic signed [41:0] quad;
    logic signed [26:0] lin;
    logic signed [42:0] p2_next;

    always_comb begin
        quad    = $signed(xy_curve_reg[15:8]) * $signed({1'b0, sqb_reg[60:28]});
        lin     = rxyb_reg[40:14];
        p2_next = $signed({quad[41], quad}) + $signed({{16{lin[26]}}, lin});
    end

    // ------------------------------------------------------------------
    // stage d: p2 + 256, clamped where the output saturates regardless
    // ------------------------------------------------------------------
    logic               vd_reg;
    raw_t               rawd_reg;
    logic [19:0]        zcd_reg;
    logic signed [33:0] p2d_reg;

    logic signed [43:0] p2s;
    logic signed [33:0] p2cl_next;

    always_comb begin
        p2s = $signed({p2c_reg[42], p2c_reg}) + 44'sd256;
        if (p2s > P2_LIM) begin
            p2cl_next = 34'(P2_LIM);
        end else if (p2s < -P2_LIM) begin
            p2cl_next = 34'(-P2_LIM);
        end else begin
            p2cl_next = 34'(p2s);
        end
    end

    // ------------------------------------------------------------------
    // stage e: times (gain + 160), per axis
    // ------------------------------------------------------------------
    logic               ve_reg;
    raw_t               rawe_reg;
    logic [19:0]        zce_reg;
    logic signed [43:0] m1x_reg, m1y_reg;

    logic signed [9:0]  gx, gy;

    always_comb begin
        gx = $signed({{2{xy_gains_reg[7]}}, xy_gains_reg[7:0]}) + 10'sd160;
        gy = $signed({{2{xy_gains_reg[15]}}, xy_gains_reg[15:8]}) + 10'sd160;
    end

    // ------------------------------------------------------------------
    // stage f: times raw value
    // ------------------------------------------------------------------
    logic               vf_reg;
    raw_t               rawf_reg;
    logic [19:0]        zcf_reg;
    logic signed [56:0] p4x_reg, p4y_reg;

    // ------------------------------------------------------------------
    // stage g (output): add offset, floor by 2^17, saturate
    // ------------------------------------------------------------------
    logic signed [NUMW-1:0] numx, numy;
    logic signed [NUMW-1:0] offx, offy;

    always_comb begin
        offx = NUMW'($signed(xy_offsets_reg[7:0])) <<< (OUT_FRAC_BITS + 16);
        offy = NUMW'($signed(xy_offsets_reg[15:8])) <<< (OUT_FRAC_BITS + 16);
        numx = (NUMW'(p4x_reg) <<< OUT_FRAC_BITS) + offx;
        numy = (NUMW'(p4y_reg) <<< OUT_FRAC_BITS) + offy;
    end

    logic               m_valid_reg;
    logic [12:0]        m_raw_x_reg, m_raw_y_reg;
    logic [14:0]        m_raw_z_reg;
    logic [13:0]        m_raw_hall_reg;
    logic [19:0]        m_comp_x_reg, m_comp_y_reg, m_comp_z_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            vc_reg      <= 1'b0;
            vd_reg      <= 1'b0;
            ve_reg      <= 1'b0;
            vf_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            va_reg      <= xdiv_valid;
            vb_reg      <= va_reg;
            vc_reg      <= vb_reg;
            vd_reg      <= vc_reg;
            ve_reg      <= vd_reg;
            vf_reg      <= ve_reg;
            m_valid_reg <= vf_reg;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (adv) begin
            // field layout: x = byte1:byte0[7:3], z = byte5:byte4[7:1]
            rx1_reg    <= {s_data_frame[15:8], s_data_frame[7:3]};
            ry1_reg    <= {s_data_frame[31:24], s_data_frame[23:19]};
            rz1_reg    <= {s_data_frame[47:40], s_data_frame[39:33]};
            rh1_reg    <= {s_data_frame[63:56], s_data_frame[55:50]};

            raw2_reg   <= raw2_next;
            zz2_reg    <= hz || (rz1_reg == Z_OVF) || (z_sens_reg == '0)
                       || (z_base_reg == '0);
            zp1_2_reg  <= zp1_next;
            zp3_2_reg  <= zp3_next;
            zdiff2_reg <= zdiff_next;

            raw3_reg   <= raw2_reg;
            zz3_reg    <= zz2_reg;
            n3_reg     <= n_next;
            sum3_reg   <= sum_next;

            rawa_reg   <= raw_d;
            ra_reg     <= r_next;
            zca_reg    <= zc_next;

            rawb_reg   <= rawa_reg;
            zcb_reg    <= zca_reg;
            sqb_reg    <= sq_full[60:0];
            rxyb_reg   <= rxy_next;

            rawc_reg   <= rawb_reg;
            zcc_reg    <= zcb_reg;
            p2c_reg    <= p2_next;

            rawd_reg   <= rawc_reg;
            zcd_reg    <= zcc_reg;
            p2d_reg    <= p2cl_next;

            rawe_reg   <= rawd_reg;
            zce_reg    <= zcd_reg;
            m1x_reg    <= p2d_reg * gx;
            m1y_reg    <= p2d_reg * gy;

            rawf_reg   <= rawe_reg;
            zcf_reg    <= zce_reg;
            p4x_reg    <= m1x_reg * $signed(rawe_reg.rx);
            p4y_reg    <= m1y_reg * $signed(rawe_reg.ry);

            m_raw_x_reg    <= rawf_reg.rx;
            m_raw_y_reg    <= rawf_reg.ry;
            m_raw_z_reg    <= rawf_reg.rz;
            m_raw_hall_reg <= rawf_reg.rh;
            m_comp_x_reg   <= rawf_reg.x_zero ? '0 : sat_out(numx[NUMW-1:17]);
            m_comp_y_reg   <= rawf_reg.y_zero ? '0 : sat_out(numy[NUMW-1:17]);
            m_comp_z_reg   <= zcf_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_raw_x    = $signed(m_raw_x_reg);
    assign m_raw_y    = $signed(m_raw_y_reg);
    assign m_raw_z    = $signed(m_raw_z_reg);
    assign m_raw_hall = m_raw_hall_reg;
    assign m_comp_x   = $signed(m_comp_x_reg);
    assign m_comp_y   = $signed(m_comp_y_reg);
    assign m_comp_z   = $signed(m_comp_z_reg);

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // both dividers must stay in lockstep
    a_div_align: assert property (@(posedge aclk) disable iff (!aresetn)
        xdiv_valid == zdiv_valid)
        else $error("divider valid bits out of step");

    // x overflow marker gives zero compensated x
    a_x_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_raw_x_reg == XY_OVF) |-> m_comp_x_reg == '0)
        else $error("x overflow marker not zeroed");

    // zero hall resistance zeroes all axes
    a_hall_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_raw_hall_reg == '0) |->
            (m_comp_x_reg == '0) && (m_comp_y_reg == '0) && (m_comp_z_reg == '0))
        else $error("zero hall resistance not zeroed");

    // nothing comes out the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// ----- rtl/core/mfc_div.sv -----
// ----------------------------------------------------------------------------
// mfc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module mfc_div #(
    parameter int NW = 39,
    parameter int DW = 23,
    parameter int PW = 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_valid,
    output logic [NW-1:0]      out_quo,
    output logic [PW-1:0]      out_pay
);

    logic          vld_reg [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [DW-1:0] den_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [PW-1:0] pay_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          cur_vld;
        logic [DW-1:0] cur_rem;
        logic [DW-1:0] cur_den;
        logic [NW-1:0] cur_num;
        logic [NW-1:0] cur_quo;
        logic [PW-1:0] cur_pay;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          fits;

        if (k == 0) begin : g_first
            assign cur_vld = in_valid;
            assign cur_rem = '0;
            assign cur_den = in_den;
            assign cur_num = in_num;
            assign cur_quo = '0;
            assign cur_pay = in_pay;
        end else begin : g_next
            assign cur_vld = vld_reg[k-1];
            assign cur_rem = rem_reg[k-1];
            assign cur_den = den_reg[k-1];
            assign cur_num = num_reg[k-1];
            assign cur_quo = quo_reg[k-1];
            assign cur_pay = pay_reg[k-1];
        end

        // bring down the next numerator bit, subtract if it fits
        assign trial = {cur_rem, cur_num[NW-1-k]};
        assign diff  = trial - {1'b0, cur_den};
        assign fits  = ~diff[DW];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= fits ? diff[DW-1:0] : trial[DW-1:0];
                quo_reg[k] <= {cur_quo[NW-2:0], fits};
                den_reg[k] <= cur_den;
                num_reg[k] <= cur_num;
                pay_reg[k] <= cur_pay;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quo   = quo_reg[NW-1];
    assign out_pay   = pay_reg[NW-1];

endmodule

`default_nettype wire
